>>> rtl/rmc_pkg.sv
// Shared types, constants and digit helpers for the RMC time extractor.
`timescale 1ns / 1ps

package rmc_pkg;

  // Bytes kept from each watched field, terminator included.
  localparam int KEEP = 6;
  // Fields at or past this index are not stored, and a plain byte there drops the sentence.
  localparam int MAX_FIELDS = 20;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] SEC_WRAP  = 8'd60;
  localparam logic [7:0] MIN_WRAP  = 8'd60;
  localparam logic [7:0] HOUR_WRAP = 8'd24;

  // Register indexes on the configuration port.
  localparam logic REG_REQUIRE_ACTIVE = 1'b0;
  localparam logic REG_ADVANCE_SECOND = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       resync;
  } rmc_in_t;

  typedef struct packed {
    logic [7:0] hour_value;
    logic [7:0] minute_value;
    logic [7:0] second_value;
    logic [7:0] day_value;
    logic [7:0] month_value;
    logic [7:0] year_value;
  } rmc_out_t;

  // Kept characters of the time and date fields, index 0 first.
  typedef struct packed {
    logic [KEEP-1:0][7:0] time_chars;
    logic [KEEP-1:0][7:0] date_chars;
  } rmc_digits_t;

  // (a - '0') * 10 + (b - '0'), modulo 256; 528 mod 256 is 16.
  function automatic logic [7:0] pair_val(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = {a[4:0], 3'b000} + {a[6:0], 1'b0};
    v = v + b - 8'd16;
    return v;
  endfunction

endpackage

>>> rtl/rmc_parser.sv
// Sentence parser: phase, checksum, field/char counters and kept field bytes.
`timescale 1ns / 1ps

module rmc_parser import rmc_pkg::*; #(
  parameter int FIELD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  rmc_in_t     item,
  input  logic        require_active,
  output logic        found,
  output rmc_digits_t digits
);

  localparam int CW = $clog2(FIELD_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_OPEN = 4'b0010,
    PH_HI   = 4'b0100,
    PH_LO   = 4'b1000
  } phase_t;

  phase_t          parse_phase, parse_phase_next;
  logic [7:0]      running_xor;
  logic [7:0]      high_digit_part;
  logic [4:0]      field_index;
  logic [CW-1:0]   char_index;
  logic [7:0]      kept [4][KEEP];

  logic [7:0] c;
  logic [5:0] hex;
  logic       is_sep;
  logic       room;
  logic       in_range;
  logic [2:0] slot;       // one-hot-free code: 0..3 slot, 4 none
  logic       wr_en;
  logic [7:0] wr_byte;
  logic [4:0] field_bump;
  logic       sum_ok;
  logic       name_ok;
  logic       status_ok;

  assign c = item.rx_byte;

  always_comb begin
    if (c >= CH_ZERO && c <= CH_NINE) begin
      hex = 6'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      hex = 6'(c - CH_UA) + 6'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      hex = 6'(c - CH_LA) + 6'd10;
    end else begin
      hex = 6'd0;
    end
  end

  always_comb begin
    case (field_index)
      5'd0:    slot = 3'd0;
      5'd1:    slot = 3'd1;
      5'd2:    slot = 3'd2;
      5'd9:    slot = 3'd3;
      default: slot = 3'd4;
    endcase
  end

  assign is_sep     = (c == CH_COMMA) || (c == CH_STAR);
  assign in_range   = field_index < 5'(MAX_FIELDS);
  assign room       = in_range && (char_index < CW'(FIELD_BYTES - 1));
  assign field_bump = (field_index == 5'd31) ? field_index : field_index + 5'd1;
  assign wr_en      = take && !item.resync && (parse_phase == PH_OPEN)
                      && (is_sep ? in_range : room)
                      && (char_index < CW'(KEEP)) && (slot != 3'd4);
  assign wr_byte    = is_sep ? CH_NUL : c;

  always_comb begin
    parse_phase_next = parse_phase;
    if (item.resync) begin
      parse_phase_next = PH_IDLE;
    end else begin
      unique case (parse_phase)
        PH_IDLE: if (c == CH_DOLLAR) parse_phase_next = PH_OPEN;
        PH_OPEN: begin
          if (c == CH_STAR) begin
            parse_phase_next = PH_HI;
          end else if (c != CH_COMMA && !room) begin
            parse_phase_next = PH_IDLE;
          end
        end
        PH_HI:   parse_phase_next = PH_LO;
        PH_LO:   parse_phase_next = PH_IDLE;
        default: parse_phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_IDLE;
      running_xor     <= 8'd0;
      high_digit_part <= 8'd0;
      field_index     <= 5'd0;
      char_index      <= '0;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      if (!item.resync) begin
        unique case (parse_phase)
          PH_IDLE: begin
            if (c == CH_DOLLAR) begin
              running_xor <= CH_STAR;
              field_index <= 5'd0;
              char_index  <= '0;
            end
          end
          PH_OPEN: begin
            running_xor <= running_xor ^ c;
            if (c == CH_COMMA) begin
              field_index <= field_bump;
              char_index  <= '0;
            end else if (c == CH_STAR) begin
              field_index <= field_bump;
            end else if (room) begin
              char_index <= char_index + CW'(1);
            end
          end
          PH_HI:   high_digit_part <= {hex[3:0], 4'b0000};
          default: ;
        endcase
      end
    end
  end

  // Kept bytes: reset to zero, written at the decoded slot and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) begin
        for (int p = 0; p < KEEP; p++) begin
          kept[s][p] <= 8'd0;
        end
      end
    end else if (wr_en) begin
      for (int s = 0; s < 4; s++) begin
        for (int p = 0; p < KEEP; p++) begin
          if (slot == 3'(s) && char_index == CW'(p)) kept[s][p] <= wr_byte;
        end
      end
    end
  end

  assign sum_ok    = {1'b0, running_xor} == ({1'b0, high_digit_part} + 9'(hex));
  assign name_ok   = kept[0][0] == CH_G && kept[0][1] == CH_P && kept[0][2] == CH_R
                     && kept[0][3] == CH_M && kept[0][4] == CH_C && kept[0][5] == CH_NUL;
  assign status_ok = !require_active || (kept[2][0] == CH_UA && kept[2][1] == CH_NUL);

  assign found = take && !item.resync && (parse_phase == PH_LO) && sum_ok
                 && (field_index > 5'd2) && name_ok && status_ok;

  always_comb begin
    for (int p = 0; p < KEEP; p++) begin
      digits.time_chars[p] = kept[1][p];
      digits.date_chars[p] = kept[3][p];
    end
  end

endmodule

>>> rtl/rmc_time_calc.sv
// Digit pairs to values, with the optional one-second advance.
`timescale 1ns / 1ps

module rmc_time_calc import rmc_pkg::*; (
  input  rmc_digits_t digits,
  input  logic        advance,
  output rmc_out_t    result
);

  logic [7:0] hh, mi, ss;
  logic [7:0] s1, m1, h1;

  assign hh = pair_val(digits.time_chars[0], digits.time_chars[1]);
  assign mi = pair_val(digits.time_chars[2], digits.time_chars[3]);
  assign ss = pair_val(digits.time_chars[4], digits.time_chars[5]);

  always_comb begin
    result.hour_value   = hh;
    result.minute_value = mi;
    result.second_value = ss;
    s1 = ss + 8'd1;
    m1 = mi + 8'd1;
    h1 = hh + 8'd1;
    if (advance) begin
      result.second_value = s1;
      if (s1 >= SEC_WRAP) begin
        result.second_value = s1 - SEC_WRAP;
        result.minute_value = m1;
        if (m1 >= MIN_WRAP) begin
          result.minute_value = m1 - MIN_WRAP;
          result.hour_value   = (h1 >= HOUR_WRAP) ? h1 - HOUR_WRAP : h1;
        end
      end
    end
    result.day_value   = pair_val(digits.date_chars[0], digits.date_chars[1]);
    result.month_value = pair_val(digits.date_chars[2], digits.date_chars[3]);
    result.year_value  = pair_val(digits.date_chars[4], digits.date_chars[5]);
  end

endmodule

>>> rtl/rmc_out_buf.sv
// Result register with one skid entry behind it.
`timescale 1ns / 1ps

module rmc_out_buf import rmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rmc_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output rmc_out_t out_data
);

  logic     skid_valid;
  rmc_out_t skid_data;
  logic     pop_ok;

  // push only arrives while the skid entry is empty
  assign full   = skid_valid;
  assign pop_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop_ok) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ok) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> rtl/nmea_rmc_time_extractor.sv
// Top level of the NMEA RMC time extractor: register port, parser, result buffer.
`timescale 1ns / 1ps

// NMEA RMC time extractor. One received byte enters per transaction on the
// input channel and, while in_stall is low, is taken in the cycle it is
// offered, one byte per clock; the parser state updates at that edge. When the
// second checksum digit of a verified GPRMC sentence (at least three fields,
// status "A" if require_active_status is set) is taken, one result transaction
// carrying hour/minute/second and day/month/year is loaded at that same edge
// into the output register, offered from the next cycle, or into the single
// skid entry behind it while a stalled result holds the output register, so
// input keeps flowing while one result waits; in_stall rises only when both
// are occupied. Registers at byte 0 (require_active_status, reset 1) and byte
// 4 (advance_one_second, reset 0) sit on the APB port and should be written
// while no sentence is in flight. resync drops the current sentence.
module nmea_rmc_time_extractor import rmc_pkg::*; #(
  parameter int FIELD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  rmc_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output rmc_out_t    out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        require_active;
  logic        advance;
  logic        take;
  logic        found;
  rmc_digits_t digits;
  rmc_out_t    result;
  logic        buf_full;

  // Register file: word select on paddr[2], low address bits ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      require_active <= 1'b1;
      advance        <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_REQUIRE_ACTIVE: require_active <= pwdata[0];
        REG_ADVANCE_SECOND: advance        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REQUIRE_ACTIVE: prdata = {31'd0, require_active};
      REG_ADVANCE_SECOND: prdata = {31'd0, advance};
      default:            prdata = 32'd0;
    endcase
  end

  // Input is held off only when both result slots are taken.
  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  rmc_parser #(
    .FIELD_BYTES (FIELD_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .item           (in_data),
    .require_active (require_active),
    .found          (found),
    .digits         (digits)
  );

  // Kept bytes are stable during the last digit, so values come straight off them.
  rmc_time_calc u_time_calc (
    .digits  (digits),
    .advance (advance),
    .result  (result)
  );

  rmc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (found),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_nmea_rmc_time_extractor.sv
// Self-checking testbench for the NMEA RMC time extractor: directed sentences, then random traffic.
`timescale 1ns / 1ps

module tb_nmea_rmc_time_extractor;
  import rmc_pkg::*;

  localparam int FIELD_LEN        = 16;
  localparam int HALF_PERIOD      = 6;
  localparam int RANDOM_ITEMS     = 900;
  localparam int DRAIN_LIMIT      = 4000;

  // Parser phases of the local predictor.
  typedef enum logic [1:0] {SCAN_HUNT, SCAN_BODY, SCAN_SUM_HI, SCAN_SUM_LO} scan_t;

  // How a directed row is framed on the wire.
  typedef enum logic [1:0] {
    ROW_SUM_OK,   // '$' + text + correct checksum
    ROW_SUM_BAD,  // '$' + text + checksum with one bit flipped
    ROW_CUT,      // '$' + text, then a resync transaction
    ROW_RAW       // text sent exactly as written
  } row_kind_t;

  typedef struct {
    string     text;     // '~' stands for a zero byte
    row_kind_t kind;
    bit        lower;    // lower-case checksum digits
    bit        req;      // require_active_status for this row
    bit        adv;      // advance_one_second for this row
    bit        typed;    // expectation written below rather than predicted
    bit        has_fix;
    rmc_out_t  fix;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rmc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rmc_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nmea_rmc_time_extractor #(.FIELD_BYTES(FIELD_LEN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and its two registers.
  // ---------------------------------------------------------------------------
  scan_t      scan_phase = SCAN_HUNT;
  logic [7:0] sum_acc = '0;
  logic [7:0] sum_hi = '0;
  int         field_no = 0;
  int         char_no = 0;
  logic [7:0] kept [4][KEEP];      // slots: name, time, status, date
  bit         cfg_req = 1'b1;
  bit         cfg_adv = 1'b0;

  rmc_out_t   pending_fixes [$];   // predicted time/date results, oldest first
  logic [7:0] line_q [$];          // bytes of the sentence being built
  int         mismatches = 0;
  int         items_sent = 0;
  bit         idle_on = 1'b0;      // random gaps and stalls allowed
  int         stall_left = 0;
  row_t       rows [19];

  initial begin
    foreach (kept[s, p]) kept[s][p] = '0;
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_UA && c <= CH_UZ) return int'(c) - int'(CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LZ) return int'(c) - int'(CH_LA) + 10;
    return 0;
  endfunction

  // Two ASCII digits to a value, wrapping at 256 like the hardware.
  function automatic logic [7:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
    int v;
    v = (int'(a) - 48) * 10 + (int'(b) - 48);
    return v[7:0];
  endfunction

  // Only fields 0, 1, 2 and 9 are watched, and only their first KEEP bytes.
  task automatic keep_char(input int f, input int pos, input logic [7:0] b);
    int s;
    case (f)
      0: s = 0;
      1: s = 1;
      2: s = 2;
      9: s = 3;
      default: s = -1;
    endcase
    if (f < MAX_FIELDS && pos < KEEP && s >= 0) kept[s][pos] = b;
  endtask

  function automatic rmc_out_t fix_of(input logic [7:0] h, input logic [7:0] mi,
                                      input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] mo, input logic [7:0] y);
    rmc_out_t f;
    f.hour_value = h;
    f.minute_value = mi;
    f.second_value = s;
    f.day_value = d;
    f.month_value = mo;
    f.year_value = y;
    return f;
  endfunction

  // One accepted input transaction through the predictor.
  task automatic parse_rx_byte(input rmc_in_t item, output bit got, output rmc_out_t fix);
    logic [7:0] c;
    logic [7:0] hh;
    logic [7:0] mi;
    logic [7:0] ss;
    int         v;
    bit         name_ok;
    bit         status_ok;
    c = item.rx_byte;
    got = 1'b0;
    fix = '0;
    if (item.resync) begin
      scan_phase = SCAN_HUNT;
      return;
    end
    case (scan_phase)
      SCAN_HUNT: begin
        if (c == CH_DOLLAR) begin
          sum_acc = CH_STAR;
          scan_phase = SCAN_BODY;
          field_no = 0;
          char_no = 0;
        end
      end
      SCAN_BODY: begin
        sum_acc ^= c;
        if (c == CH_COMMA) begin
          keep_char(field_no, char_no, CH_NUL);
          if (field_no < 31) field_no++;
          char_no = 0;
        end else if (c == CH_STAR) begin
          keep_char(field_no, char_no, CH_NUL);
          if (field_no < 31) field_no++;
          scan_phase = SCAN_SUM_HI;
        end else if (field_no < MAX_FIELDS && char_no < FIELD_LEN - 1) begin
          keep_char(field_no, char_no, c);
          char_no++;
        end else begin
          scan_phase = SCAN_HUNT;
        end
      end
      SCAN_SUM_HI: begin
        v = hex_digit(c) * 16;
        sum_hi = v[7:0];
        scan_phase = SCAN_SUM_LO;
      end
      default: begin
        scan_phase = SCAN_HUNT;
        name_ok = kept[0][0] == CH_G && kept[0][1] == CH_P && kept[0][2] == CH_R &&
                  kept[0][3] == CH_M && kept[0][4] == CH_C && kept[0][5] == CH_NUL;
        status_ok = kept[2][0] == CH_UA && kept[2][1] == CH_NUL;
        // checksum compare is done without wrap: letters above F can overshoot 255
        if (int'(sum_acc) == int'(sum_hi) + hex_digit(c) && field_no > 2 && name_ok &&
            (!cfg_req || status_ok)) begin
          hh = digit_pair(kept[1][0], kept[1][1]);
          mi = digit_pair(kept[1][2], kept[1][3]);
          ss = digit_pair(kept[1][4], kept[1][5]);
          if (cfg_adv) begin
            ss = ss + 8'd1;
            if (ss >= SEC_WRAP) begin
              ss = ss - SEC_WRAP;
              mi = mi + 8'd1;
              if (mi >= MIN_WRAP) begin
                mi = mi - MIN_WRAP;
                hh = hh + 8'd1;
                if (hh >= HOUR_WRAP) hh = hh - HOUR_WRAP;
              end
            end
          end
          got = 1'b1;
          fix = fix_of(hh, mi, ss, digit_pair(kept[3][0], kept[3][1]),
                       digit_pair(kept[3][2], kept[3][3]),
                       digit_pair(kept[3][4], kept[3][5]));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the comparison against the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    rmc_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fixes.size() == 0) begin
        report($sformatf("result transaction %h with nothing expected", out_data));
      end else begin
        want = pending_fixes.pop_front();
        check_field("hour", out_data.hour_value, want.hour_value);
        check_field("minute", out_data.minute_value, want.minute_value);
        check_field("second", out_data.second_value, want.second_value);
        check_field("day", out_data.day_value, want.day_value);
        check_field("month", out_data.month_value, want.month_value);
        check_field("year", out_data.year_value, want.year_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one transaction, optionally after an idle burst, and returns at the
  // edge where it is taken. The prediction is queued at that same edge, so it
  // is always in place before the result can appear.
  task automatic send_item(input logic [7:0] b, input bit resync, input bit use_model);
    rmc_in_t  item;
    bit       got;
    rmc_out_t fix;
    item.rx_byte = b;
    item.resync = resync;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    parse_rx_byte(item, got, fix);
    if (got && use_model) pending_fixes.push_back(fix);
  endtask

  task automatic send_line(input bit use_model);
    foreach (line_q[i]) send_item(line_q[i], 1'b0, use_model);
    line_q.delete();
  endtask

  task automatic put_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == "~") c = CH_NUL;
      line_q.push_back(c);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_ZERO + n;
    return (lower ? CH_LA : CH_UA) + n - 8'd10;
  endfunction

  // Appends '*' and two hex digits of the XOR over everything after '$'.
  task automatic put_sum(input logic [7:0] flip, input bit lower);
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < line_q.size(); i++) s ^= line_q[i];
    s ^= flip;
    line_q.push_back(CH_STAR);
    line_q.push_back(hex_char(s[7:4], lower));
    line_q.push_back(hex_char(s[3:0], lower));
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Any byte that does not split the sentence.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return rand_digit();
    do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA || c == CH_STAR);
    return c;
  endfunction

  // A mostly well-formed RMC line with random content; values near the
  // carry boundaries are favoured so the one-second advance gets exercised.
  task automatic build_rmc_line();
    logic [7:0] flip;
    line_q.delete();
    line_q.push_back(CH_DOLLAR);
    case ($urandom_range(0, 9))
      0: put_text("GPGGA");
      1: put_text("GPRM");
      default: put_text("GPRMC");
    endcase
    line_q.push_back(CH_COMMA);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 8)) line_q.push_back(filler_char());
    end else begin
      if ($urandom_range(0, 3) == 0) put_text("23");
      else repeat (2) line_q.push_back(rand_digit());
      if ($urandom_range(0, 2) == 0) put_text("59");
      else repeat (2) line_q.push_back(rand_digit());
      if ($urandom_range(0, 2) == 0) put_text("59");
      else repeat (2) line_q.push_back(rand_digit());
    end
    line_q.push_back(CH_COMMA);
    case ($urandom_range(0, 19))
      0: put_text("V");
      1: ;
      2: put_text("AA");
      3: line_q.push_back(filler_char());
      default: put_text("A");
    endcase
    // now and then the line stops after the status field
    if ($urandom_range(0, 9) != 0) begin
      for (int k = 3; k <= 8; k++) begin
        line_q.push_back(CH_COMMA);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) line_q.push_back(rand_digit());
      end
      line_q.push_back(CH_COMMA);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(0, 8)) line_q.push_back(filler_char());
      else repeat (6) line_q.push_back(rand_digit());
      // surplus fields; a digit past the field limit drops the line
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 30)) begin
          line_q.push_back(CH_COMMA);
          if ($urandom_range(0, 3) == 0) line_q.push_back(rand_digit());
        end
      end
    end
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    put_sum(flip, 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Register port and phase changes.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_REQUIRE_ACTIVE) cfg_req = value[0];
    else cfg_adv = value[0];
    @(posedge clk);
  endtask

  // Stop offering input, let every predicted result arrive, then allow for
  // the output register and skid entry to empty.
  task automatic settle();
    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending_fixes.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // resync first so no sentence is in flight when the registers change
  task automatic set_mode(input bit req, input bit adv);
    send_item(CH_DOLLAR, 1'b1, 1'b1);
    settle();
    write_reg(REG_REQUIRE_ACTIVE, {31'd0, req});
    write_reg(REG_ADVANCE_SECOND, {31'd0, adv});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    bit [1:0] modes [5];
    int       cut;
    int       sel;
    int       phase_start;
    bit       last_phase;

    rows[0]  = '{"GPRMC,123456,A,,,,,,,010203", ROW_SUM_OK, 0, 1, 0, 1, 1,
                 fix_of(12, 34, 56, 1, 2, 3)};
    rows[1]  = '{"GPRMC,123456,A,,,,,,,010203", ROW_SUM_BAD, 0, 1, 0, 1, 0, '0};
    rows[2]  = '{"GPRMC,123456,V,,,,,,,010203", ROW_SUM_OK, 0, 1, 0, 1, 0, '0};
    rows[3]  = '{"GPGGA,123456,A,,,,,,,010203", ROW_SUM_OK, 0, 1, 0, 1, 0, '0};
    rows[4]  = '{"GPRMC,999999,A,,,,,,,999999", ROW_SUM_OK, 1, 1, 0, 1, 1,
                 fix_of(99, 99, 99, 99, 99, 99)};
    rows[5]  = '{"GPRMC,000000,A,,,,,,,000000", ROW_SUM_OK, 0, 1, 0, 1, 1,
                 fix_of(0, 0, 0, 0, 0, 0)};
    // only two fields before the checksum
    rows[6]  = '{"GPRMC,123456", ROW_SUM_OK, 0, 1, 0, 1, 0, '0};
    // time field too long: dropped, the tail is ignored while hunting for '$'
    rows[7]  = '{"GPRMC,1234567890123456,A,,,,,,,010203", ROW_SUM_OK, 0, 1, 0, 1, 0, '0};
    rows[8]  = '{"GPRMC,123456,A,,,", ROW_CUT, 0, 1, 0, 1, 0, '0};
    rows[9]  = '{"GPRMC,101010,V,,,,,,,010203", ROW_SUM_OK, 0, 0, 0, 0, 0, '0};
    // full carry through seconds, minutes and hours
    rows[10] = '{"GPRMC,235959,A,,,,,,,311299", ROW_SUM_OK, 0, 1, 1, 1, 1,
                 fix_of(0, 0, 0, 31, 12, 99)};
    rows[11] = '{"GPRMC,105959,A,,,,,,,010203", ROW_SUM_OK, 1, 1, 1, 0, 0, '0};
    // short digit fields pick up terminators and stale bytes
    rows[12] = '{"GPRMC,12,A,,,,,,,01", ROW_SUM_OK, 0, 1, 1, 0, 0, '0};
    // exactly three fields, date left over from earlier lines
    rows[13] = '{"GPRMC,123456,A", ROW_SUM_OK, 0, 1, 1, 0, 0, '0};
    // zero bytes inside the name and status fields end the comparison
    rows[14] = '{"GPRMC~X,123456,A~Z,,,,,,,010203", ROW_SUM_OK, 0, 1, 0, 0, 0, '0};
    // field counter saturates, nothing written for the surplus fields
    rows[15] = '{"GPRMC,123456,A,,,,,,,010203,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,",
                 ROW_SUM_OK, 0, 0, 0, 0, 0, '0};
    // a plain byte beyond the field limit drops the line
    rows[16] = '{"GPRMC,123456,A,,,,,,,010203,,,,,,,,,,,X", ROW_SUM_OK, 0, 0, 0, 1, 0, '0};
    // '$' inside a line is plain data; checksum digits beyond F
    rows[17] = '{"$GP$GPRMC,123456,A,,,,,,,010203*ZZ", ROW_RAW, 0, 0, 0, 0, 0, '0};
    // resync between the two checksum digits
    rows[18] = '{"GPRMC,123456,A,,,,,,,010203*4", ROW_CUT, 0, 0, 0, 1, 0, '0};

    modes = '{2'b10, 2'b01, 2'b11, 2'b00, 2'b10};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // directed rows
    foreach (rows[r]) begin
      if (rows[r].req != cfg_req || rows[r].adv != cfg_adv) set_mode(rows[r].req, rows[r].adv);
      if (rows[r].kind != ROW_RAW) line_q.push_back(CH_DOLLAR);
      put_text(rows[r].text);
      if (rows[r].kind == ROW_SUM_OK) put_sum(8'h00, rows[r].lower);
      if (rows[r].kind == ROW_SUM_BAD) put_sum(8'h01, rows[r].lower);
      send_line(!rows[r].typed);
      if (rows[r].kind == ROW_CUT) send_item(CH_DOLLAR, 1'b1, !rows[r].typed);
      if (rows[r].typed && rows[r].has_fix) pending_fixes.push_back(rows[r].fix);
    end

    // five random phases, each under one register setting (every setting at least once); the last runs without idling
    for (int p = 0; p < 5; p++) begin
      last_phase = (p == 4);
      set_mode(modes[p][1], modes[p][0]);
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / 5) begin
        idle_on = !last_phase && ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          build_rmc_line();
          send_line(1'b1);
        end else if (sel < 88) begin
          // broken line: cut short, then either resync or run on into noise
          build_rmc_line();
          cut = $urandom_range(1, line_q.size() - 1);
          for (int i = 0; i < cut; i++) send_item(line_q[i], 1'b0, 1'b1);
          line_q.delete();
          if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else begin
          repeat ($urandom_range(1, 8))
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
        end
      end
    end

    idle_on = 1'b0;
    settle();
    while (pending_fixes.size() != 0) begin
      report($sformatf("expected result %h never arrived", pending_fixes.pop_front()));
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
